/* rtl/core/rbb_pkg.sv */
package rbb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int IN_ROW_W   = 13;
   localparam int OUT_ROW_W  = 12;

   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int SUM_W      = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // floor(s / 9) = (s * 3641) >> 15 for s <= 2295
   localparam int PROD_W     = 2 * SUM_W;
   localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);
   localparam int DIV9_SHIFT = 15;

   typedef logic [PIX_W-1:0] pixel_type;

   // [0] top row, [1] middle row, [2] bottom row
   typedef logic [2:0][PIX_W-1:0] column_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_entry_type;

   typedef struct packed {
      logic [COL_W-1:0] addr;
      pixel_type        pix;
      logic             top_sel;
      logic             mid_sel;
      logic             emit;
      logic             fend;
      logic             first_col;
      logic             add_left;
      logic             wide;
   } s1_type;

   typedef struct packed {
      logic [2:0][SUM_W-1:0] sum;
      logic                  fend;
   } s2_type;

   typedef struct packed {
      logic [2:0][CH_W-1:0] mean;
      logic                 fend;
   } rsp_item_type;

endpackage

/* rtl/core/rgb_box_blur_3x3_core.sv */
// Each result item is registered in s1 and s2 and then queued in the result FIFO.
// Image lag: the mean of a pixel comes out one row plus one pixel after that pixel.
// One item per clock while the result FIFO has room; one line-memory read and write each.
// Reset: counters and window cleared, width 640, height 480; line memory is not cleared.
module rgb_box_blur_3x3_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbb_pkg::PIX_W-1:0]       req_tdata,  // pixel_red, pixel_green, pixel_blue
   input  logic                            req_tuser,  // flush
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbb_pkg::PIX_W-1:0]       rsp_tdata,  // out_red, out_green, out_blue
   output logic                            rsp_tlast,  // frame_end
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                            accept;
   logic                            restart;
   logic [rbb_pkg::COL_W-1:0]       rd_addr;
   logic                            s1_valid;
   rbb_pkg::s1_type                 s1;
   rbb_pkg::line_entry_type         rd_entry;
   logic                            wr_en;
   logic [rbb_pkg::COL_W-1:0]       wr_addr;
   rbb_pkg::line_entry_type         wr_entry;
   logic                            s2_valid;
   rbb_pkg::s2_type                 s2;
   logic [rbb_pkg::FIFO_CNT_W-1:0]  fill;
   logic [rbb_pkg::FIFO_CNT_W-1:0]  in_flight;

   // every item in the pipe may still need a result slot
   assign in_flight  = fill + rbb_pkg::FIFO_CNT_W'(s1_valid) + rbb_pkg::FIFO_CNT_W'(s2_valid);
   assign req_tready = (in_flight < rbb_pkg::FIFO_CNT_W'(rbb_pkg::FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   rbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .pix_data  (req_tdata),
      .flush     (req_tuser),
      .rd_addr   (rd_addr),
      .restart   (restart),
      .s1_valid  (s1_valid),
      .s1        (s1)
   );

   rbb_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   rbb_window u_window (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .s1_valid (s1_valid),
      .s1       (s1),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   rbb_mean_out u_mean_out (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2         (s2),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fill       (fill)
   );

endmodule

/* rtl/core/rbb_ctrl.sv */
module rbb_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [rbb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            accept,
   input  rbb_pkg::pixel_type              pix_data,
   input  logic                            flush,
   output logic [rbb_pkg::COL_W-1:0]       rd_addr,
   output logic                            restart,
   output logic                            s1_valid,
   output rbb_pkg::s1_type                 s1
);

   logic [rbb_pkg::FW_W-1:0]      width_ff, width_in;
   logic [rbb_pkg::FH_W-1:0]      height_ff, height_in;
   logic [rbb_pkg::COL_W-1:0]     in_col_ff, in_col_in;
   logic [rbb_pkg::IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [rbb_pkg::COL_W-1:0]     out_col_ff, out_col_in;
   logic [rbb_pkg::OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic                          s1_valid_ff, s1_valid_in;
   rbb_pkg::s1_type               s1_ff, s1_in;

   logic [rbb_pkg::FW_W-1:0]      eff_w, w_last, ic_inc, oc_inc;
   logic [rbb_pkg::FH_W-1:0]      eff_h, h_last;
   logic                          emit, fend, csr_hit;

   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = rbb_pkg::FW_W'(1);
      end else if (width_ff > rbb_pkg::FW_W'(rbb_pkg::MAX_WIDTH)) begin
         eff_w = rbb_pkg::FW_W'(rbb_pkg::MAX_WIDTH);
      end
      eff_h = height_ff;
      if (height_ff == '0) begin
         eff_h = rbb_pkg::FH_W'(1);
      end else if (height_ff > rbb_pkg::FH_W'(rbb_pkg::MAX_HEIGHT)) begin
         eff_h = rbb_pkg::FH_W'(rbb_pkg::MAX_HEIGHT);
      end
      w_last = eff_w - rbb_pkg::FW_W'(1);
      h_last = eff_h - rbb_pkg::FH_W'(1);

      emit = (in_col_ff == '0) ? (in_row_ff >= rbb_pkg::IN_ROW_W'(2))
                               : (in_row_ff >= rbb_pkg::IN_ROW_W'(1));
      fend = emit && (out_row_ff == h_last[rbb_pkg::OUT_ROW_W-1:0])
                  && (out_col_ff == w_last[rbb_pkg::COL_W-1:0]);
      ic_inc = rbb_pkg::FW_W'(in_col_ff) + rbb_pkg::FW_W'(1);
      oc_inc = rbb_pkg::FW_W'(out_col_ff) + rbb_pkg::FW_W'(1);

      s1_in.addr      = in_col_ff;
      s1_in.pix       = (!flush && (in_row_ff < eff_h)) ? pix_data : '0;
      s1_in.top_sel   = (in_row_ff >= rbb_pkg::IN_ROW_W'(2)) &&
                        ((in_row_ff - rbb_pkg::IN_ROW_W'(2)) < eff_h);
      s1_in.mid_sel   = (in_row_ff >= rbb_pkg::IN_ROW_W'(1)) &&
                        ((in_row_ff - rbb_pkg::IN_ROW_W'(1)) < eff_h);
      s1_in.emit      = emit;
      s1_in.fend      = fend;
      s1_in.first_col = (in_col_ff == '0);
      s1_in.add_left  = (in_col_ff > rbb_pkg::COL_W'(1));
      s1_in.wide      = (eff_w > rbb_pkg::FW_W'(1));
      s1_valid_in     = accept;

      csr_hit   = csr_valid && ((csr_index == rbb_pkg::CSR_FRAME_WIDTH) ||
                                (csr_index == rbb_pkg::CSR_FRAME_HEIGHT));
      width_in  = width_ff;
      height_in = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (csr_hit) begin
         if (csr_index == rbb_pkg::CSR_FRAME_WIDTH) begin
            width_in = csr_data[rbb_pkg::FW_W-1:0];
         end else begin
            height_in = csr_data[rbb_pkg::FH_W-1:0];
         end
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (fend) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (ic_inc >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + rbb_pkg::IN_ROW_W'(1);
            end else begin
               in_col_in = ic_inc[rbb_pkg::COL_W-1:0];
            end
            if (emit) begin
               if (oc_inc >= eff_w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + rbb_pkg::OUT_ROW_W'(1);
               end else begin
                  out_col_in = oc_inc[rbb_pkg::COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rbb_pkg::FRAME_WIDTH_RESET;
         height_ff   <= rbb_pkg::FRAME_HEIGHT_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign rd_addr  = in_col_ff;
   assign restart  = csr_hit;
   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

/* rtl/core/rbb_line_buf.sv */
module rbb_line_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [rbb_pkg::COL_W-1:0]   rd_addr,
   output rbb_pkg::line_entry_type     rd_entry,
   input  logic                        wr_en,
   input  logic [rbb_pkg::COL_W-1:0]   wr_addr,
   input  rbb_pkg::line_entry_type     wr_entry
);

   rbb_pkg::line_entry_type mem [rbb_pkg::MAX_WIDTH];
   rbb_pkg::line_entry_type rd_data_ff;
   rbb_pkg::line_entry_type fwd_data_ff;
   logic                    fwd_ff;

   // same-address write in the read cycle (one-pixel rows): bypass it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_entry;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_entry = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

/* rtl/core/rbb_window.sv */
module rbb_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        s1_valid,
   input  rbb_pkg::s1_type             s1,
   input  rbb_pkg::line_entry_type     rd_entry,
   output logic                        wr_en,
   output logic [rbb_pkg::COL_W-1:0]   wr_addr,
   output rbb_pkg::line_entry_type     wr_entry,
   output logic                        s2_valid,
   output rbb_pkg::s2_type             s2
);

   rbb_pkg::column_type win_ff [3];
   rbb_pkg::column_type win_in [3];
   rbb_pkg::column_type new_col;
   logic                s2_valid_ff, s2_valid_in;
   rbb_pkg::s2_type     s2_ff, s2_in;
   logic [rbb_pkg::SUM_W-1:0] cs1, cs2, csn;

   function automatic logic [rbb_pkg::SUM_W-1:0] col_sum(rbb_pkg::column_type col, int ch);
      logic [rbb_pkg::SUM_W-1:0] acc;
      acc = '0;
      for (int r = 0; r < 3; r++) begin
         acc = acc + rbb_pkg::SUM_W'(col[r][ch*rbb_pkg::CH_W +: rbb_pkg::CH_W]);
      end
      return acc;
   endfunction

   always_comb begin
      new_col[0] = s1.top_sel ? rd_entry.upper : '0;
      new_col[1] = s1.mid_sel ? rd_entry.middle : '0;
      new_col[2] = s1.pix;

      cs1 = '0;
      cs2 = '0;
      csn = '0;
      for (int ch = 0; ch < 3; ch++) begin
         cs1 = col_sum(win_ff[1], ch);
         cs2 = col_sum(win_ff[2], ch);
         csn = col_sum(new_col, ch);
         // row end: window before the shift, right column outside the frame
         if (s1.first_col) begin
            s2_in.sum[ch] = (s1.wide ? cs1 : '0) + cs2;
         end else begin
            s2_in.sum[ch] = (s1.add_left ? cs1 : '0) + cs2 + csn;
         end
      end
      s2_in.fend  = s1.fend;
      s2_valid_in = s1_valid && s1.emit;

      win_in = win_ff;
      if (restart || (s1_valid && s1.fend)) begin
         for (int c = 0; c < 3; c++) begin
            win_in[c] = '0;
         end
      end else if (s1_valid) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = new_col;
      end

      wr_en           = s1_valid;
      wr_addr         = s1.addr;
      wr_entry.upper  = rd_entry.middle;
      wr_entry.middle = s1.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            win_ff[c] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

/* rtl/core/rbb_mean_out.sv */
module rbb_mean_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            s2_valid,
   input  rbb_pkg::s2_type                 s2,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [rbb_pkg::PIX_W-1:0]       rsp_tdata,
   output logic                            rsp_tlast,
   output logic [rbb_pkg::FIFO_CNT_W-1:0]  fill
);

   rbb_pkg::rsp_item_type           fifo_ff [rbb_pkg::FIFO_DEPTH];
   logic [rbb_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rbb_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rbb_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [rbb_pkg::PROD_W-1:0]      prod;
   rbb_pkg::rsp_item_type           push_item;
   logic                            pop;

   always_comb begin
      prod = '0;
      for (int ch = 0; ch < 3; ch++) begin
         prod = rbb_pkg::PROD_W'(s2.sum[ch]) * rbb_pkg::PROD_W'(rbb_pkg::DIV9_MUL);
         push_item.mean[ch] = prod[rbb_pkg::DIV9_SHIFT +: rbb_pkg::CH_W];
      end
      push_item.fend = s2.fend;

      pop       = rsp_tvalid && rsp_tready;
      wr_ptr_in = s2_valid ? wr_ptr_ff + rbb_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rbb_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + rbb_pkg::FIFO_CNT_W'(s2_valid) - rbb_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (s2_valid) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].mean;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].fend;
   assign fill       = count_ff;

endmodule

/* verif/rgb_box_blur_3x3_core_tb.sv */
`timescale 1ns / 1ps

module rgb_box_blur_3x3_core_tb;

   localparam logic [rbb_pkg::CSR_IDX_W-1:0] CSR_SPARE = rbb_pkg::CSR_IDX_W'(3);
   localparam int MEAN_DIVISOR = 9;
   localparam int STALL_PCT    = 54;
   localparam int BOTH_PCT     = 17;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 150;

   localparam rbb_pkg::pixel_type FIELD_PATTERNS [8] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'h555555, 24'hAAAAAA, 24'h807F01
   };

   typedef struct packed {
      rbb_pkg::pixel_type data;
      logic               flush;
   } pixel_item_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rbb_pkg::PIX_W-1:0]      req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rbb_pkg::PIX_W-1:0]      rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [rbb_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [rbb_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   rgb_box_blur_3x3_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pixel_item_type        pixel_queue [$];
   rbb_pkg::rsp_item_type mean_queue [$];
   pixel_item_type        next_pixel;
   rbb_pkg::rsp_item_type want_mean;

   // blur model state
   logic [rbb_pkg::FW_W-1:0] width_reg;
   logic [rbb_pkg::FH_W-1:0] height_reg;
   rbb_pkg::pixel_type       upper_line [rbb_pkg::MAX_WIDTH];
   rbb_pkg::pixel_type       middle_line [rbb_pkg::MAX_WIDTH];
   rbb_pkg::pixel_type       blur_win [9];   // column * 3 + row, column 0 = left
   int                       in_col, in_row, out_col, out_row;

   string chan_name [3] = '{"out_red", "out_green", "out_blue"};

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit rsp_hold       = 1'b0;
   bit hold_go        = 1'b0;
   bit req_fire       = 1'b0;
   int failures       = 0;
   int items_queued   = 0;
   int items_in       = 0;
   int means_checked  = 0;
   int frame_ends     = 0;
   int reg_writes     = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void restart_frame();
      blur_win = '{default: '0};
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
   endfunction

   function automatic rbb_pkg::rsp_item_type window_mean(int first_col);
      int                    acc [3];
      rbb_pkg::rsp_item_type res;
      acc = '{0, 0, 0};
      for (int c = first_col; c < 3; c++)
         for (int r = 0; r < 3; r++)
            for (int ch = 0; ch < 3; ch++)
               acc[ch] += blur_win[c * 3 + r][ch * rbb_pkg::CH_W +: rbb_pkg::CH_W];
      for (int ch = 0; ch < 3; ch++)
         res.mean[ch] = rbb_pkg::CH_W'(acc[ch] / MEAN_DIVISOR);
      res.fend = 1'b0;
      return res;
   endfunction

   function automatic void shift_column(rbb_pkg::pixel_type top_p,
                                        rbb_pkg::pixel_type mid_p,
                                        rbb_pkg::pixel_type bot_p);
      for (int i = 0; i < 6; i++)
         blur_win[i] = blur_win[i + 3];
      blur_win[6] = top_p;
      blur_win[7] = mid_p;
      blur_win[8] = bot_p;
   endfunction

   function automatic void apply_setting(logic [rbb_pkg::CSR_IDX_W-1:0] idx,
                                         logic [rbb_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         rbb_pkg::CSR_FRAME_WIDTH: begin
            width_reg = val[rbb_pkg::FW_W-1:0];
            restart_frame();
         end
         rbb_pkg::CSR_FRAME_HEIGHT: begin
            height_reg = val[rbb_pkg::FH_W-1:0];
            restart_frame();
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_mean(rbb_pkg::pixel_type px_in, logic flush_in);
      int                    w, h, ic, ir;
      rbb_pkg::pixel_type    pix, up, mid, top_p, mid_p;
      rbb_pkg::rsp_item_type res;
      bit                    emit;
      w = (width_reg == 0) ? 1 :
          (width_reg > rbb_pkg::MAX_WIDTH) ? rbb_pkg::MAX_WIDTH : int'(width_reg);
      h = (height_reg == 0) ? 1 :
          (height_reg > rbb_pkg::MAX_HEIGHT) ? rbb_pkg::MAX_HEIGHT : int'(height_reg);
      ic   = in_col;
      ir   = in_row;
      emit = 1'b0;
      pix  = (!flush_in && ir < h) ? px_in : '0;
      up   = upper_line[ic];
      mid  = middle_line[ic];
      upper_line[ic]  = mid;
      middle_line[ic] = pix;
      top_p = (ir >= 2 && ir - 2 < h) ? up : '0;
      mid_p = (ir >= 1 && ir - 1 < h) ? mid : '0;
      if (ic == 0) begin
         // row wrap: finish the previous row with a zero right column
         if (ir >= 2) begin
            emit = 1'b1;
            res  = window_mean(w > 1 ? 1 : 2);
         end
         shift_column(top_p, mid_p, pix);
      end else begin
         shift_column(top_p, mid_p, pix);
         if (ir >= 1) begin
            emit = 1'b1;
            res  = window_mean(ic > 1 ? 0 : 1);
         end
      end
      ic++;
      if (ic >= w) begin
         ic = 0;
         ir++;
      end
      in_col = ic;
      in_row = ir & 'h1FFF;
      if (emit) begin
         res.fend = (out_row == h - 1 && out_col == w - 1);
         mean_queue.push_back(res);
         if (res.fend) begin
            restart_frame();
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row = (out_row + 1) & 'hFFF;
            end
         end
      end
   endfunction

   // sample at the rising edge: settings, input items, result items
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_setting(csr_index, csr_data);
            reg_writes++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (mean_queue.size() == 0) begin
               $error("unexpected result item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want_mean = mean_queue.pop_front();
               for (int ch = 0; ch < 3; ch++)
                  if (rsp_tdata[ch * rbb_pkg::CH_W +: rbb_pkg::CH_W] !== want_mean.mean[ch])
                  begin
                     $error("%s mismatch: expected %0d, actual %0d", chan_name[ch],
                            want_mean.mean[ch],
                            rsp_tdata[ch * rbb_pkg::CH_W +: rbb_pkg::CH_W]);
                     failures++;
                  end
               if (rsp_tlast !== want_mean.fend) begin
                  $error("frame_end mismatch: expected %0d, actual %0d",
                         want_mean.fend, rsp_tlast);
                  failures++;
               end
               means_checked++;
               if (want_mean.fend)
                  frame_ends++;
            end
         end
         if (req_fire) begin
            predict_mean(req_tdata, req_tuser);
            items_in++;
         end
      end
   end

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         req_tvalid <= 1'b1;
      end else if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         next_pixel = pixel_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= next_pixel.data;
         req_tuser  <= next_pixel.flush;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic rbb_pkg::pixel_type random_pixel();
      rbb_pkg::pixel_type px;
      for (int ch = 0; ch < 3; ch++)
         case ($urandom_range(7))
            0:       px[ch * rbb_pkg::CH_W +: rbb_pkg::CH_W] = '0;
            1:       px[ch * rbb_pkg::CH_W +: rbb_pkg::CH_W] = '1;
            default: px[ch * rbb_pkg::CH_W +: rbb_pkg::CH_W] = rbb_pkg::CH_W'($urandom);
         endcase
      return px;
   endfunction

   function automatic void push_item(rbb_pkg::pixel_type px, logic flush_in);
      pixel_item_type pi;
      pi.data  = px;
      pi.flush = flush_in;
      pixel_queue.push_back(pi);
      items_queued++;
   endfunction

   // one frame in raster order plus the drain tail; a broken frame is cut short
   function automatic void queue_frame(int w, int h, bit broken);
      int n_pix, n_tail;
      n_pix  = w * h;
      n_tail = w + 1;
      if (broken) begin
         n_pix  = $urandom_range(n_pix);
         n_tail = $urandom_range(n_tail);
      end
      for (int i = 0; i < n_pix; i++)
         push_item(random_pixel(), $urandom_range(99) < 5);
      for (int i = 0; i < n_tail; i++)
         push_item(random_pixel(), $urandom_range(99) >= 20);
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || mean_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rbb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rbb_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [rbb_pkg::CSR_DATA_W-1:0] wv,
                            input logic [rbb_pkg::CSR_DATA_W-1:0] hv);
      wait_drained();
      if ($urandom_range(1)) begin
         write_reg(rbb_pkg::CSR_FRAME_WIDTH, wv);
         write_reg(rbb_pkg::CSR_FRAME_HEIGHT, hv);
      end else begin
         write_reg(rbb_pkg::CSR_FRAME_HEIGHT, hv);
         write_reg(rbb_pkg::CSR_FRAME_WIDTH, wv);
      end
   endtask

   initial begin
      int w, h, mark;
      width_reg  = rbb_pkg::FRAME_WIDTH_RESET;
      height_reg = rbb_pkg::FRAME_HEIGHT_RESET;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      restart_frame();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry: field extremes open row 0, outputs start once row 1 begins
      for (int i = 0; i < 8; i++)
         push_item(FIELD_PATTERNS[i], 1'b0);
      push_item(24'hFFFFFF, 1'b1);
      while (items_queued < 660)
         push_item(random_pixel(), $urandom_range(99) < 5);

      // 3x3 all white: full-scale center, border sums divided by 9
      set_frame(3, 3);
      repeat (9) push_item(24'hFFFFFF, 1'b0);
      push_item(24'h000000, 1'b1);
      push_item(24'h123456, 1'b0);
      push_item(24'h000000, 1'b1);
      push_item(24'h000000, 1'b1);

      // zero width and height act as 1
      set_frame(0, 0);
      push_item(24'hC3A55A, 1'b0);
      push_item(24'hFFFFFF, 1'b0);
      push_item(24'h000000, 1'b1);

      // flush inside the frame is a black pixel
      set_frame(2, 2);
      push_item(24'h000000, 1'b0);
      push_item(24'hFFFFFF, 1'b1);
      push_item(24'h555555, 1'b0);
      push_item(24'hAAAAAA, 1'b0);
      repeat (3) push_item(24'h000000, 1'b1);

      // write to an unused index leaves the geometry alone
      wait_drained();
      write_reg(CSR_SPARE, 16'hFFFF);
      queue_frame(2, 2, 1'b0);

      for (int mode = 0; mode < 4; mode++) begin
         wait_drained();
         case (mode)
            0: begin send_idle_pct = 0;         recv_stall_pct = 0;         end
            1: begin send_idle_pct = STALL_PCT; recv_stall_pct = 0;         end
            2: begin send_idle_pct = 0;         recv_stall_pct = STALL_PCT; end
            default: begin send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
         endcase
         mark = items_queued;
         while (items_queued - mark < RANDOM_ITEMS) begin
            case ($urandom_range(19))
               0:       w = $urandom_range(100, 41);
               1, 2, 3: w = $urandom_range(40, 11);
               default: w = $urandom_range(10, 1);
            endcase
            h = (w > 40) ? $urandom_range(3, 1) : $urandom_range(8, 1);
            set_frame((w == 1 && $urandom_range(1)) ? 0 : w,
                      (h == 1 && $urandom_range(1)) ? 0 : h);
            repeat ($urandom_range(2, 1))
               queue_frame(w, h, $urandom_range(99) < 10);
         end
      end

      // backpressure: receiver holds off while a long frame is offered
      set_frame(16, 8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_frame(16, 8, 1'b0);
      hold_go = 1'b1;

      // oversized register values: widest and tallest geometries, first rows only
      set_frame(16'hFFFF, 2);
      repeat (40) push_item(random_pixel(), 1'b0);
      set_frame(1, 16'hFFFF);
      repeat (40) push_item(random_pixel(), $urandom_range(99) < 5);

      wait_drained();
      $display("run: %0d pixel items accepted, %0d register writes", items_in, reg_writes);
      $display("run: %0d mean items checked, %0d frames completed", means_checked, frame_ends);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
